/* rtl/transport_server_connection_table_defines.svh */
// Assertion macros used by the connection table back end (tsct_back).
`ifndef TRANSPORT_SERVER_CONNECTION_TABLE_DEFINES_SVH
`define TRANSPORT_SERVER_CONNECTION_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tsct_pkg.sv */
// Types and constants shared by the connection table modules.
`timescale 1ns / 1ps
package tsct_pkg;

  localparam int ENTRY_W = 4;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FAIL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  localparam logic REPLY_SYNACK = 1'b0;
  localparam logic REPLY_FINACK = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  socket_id;
    logic [15:0] local_port;
    logic [1:0]  seg_kind;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dest_port;
    logic [31:0] seg_seq;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_id;
    logic        now_connected;
    logic        reply_valid;
    logic        reply_kind;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_seq;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_LISTEN,
    OP_CLOSE,
    OP_SEG,
    OP_TIMEOUT,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        sid_ok;
    logic [3:0]  sid;
    logic [15:0] lport;
    logic        is_syn;
    logic        is_fin;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
  } cmd_t;

endpackage

/* rtl/tsct_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
`timescale 1ns / 1ps
interface tsct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/tsct_front.sv */
// Front end: accepts input transfers and classifies them into commands.
`timescale 1ns / 1ps
module tsct_front import tsct_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  tsct_stream_if.sink in_ch,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam logic [2:0] MODE_OPEN    = 3'd0;
  localparam logic [2:0] MODE_LISTEN  = 3'd1;
  localparam logic [2:0] MODE_CLOSE   = 3'd2;
  localparam logic [2:0] MODE_SEG     = 3'd3;
  localparam logic [2:0] MODE_TIMEOUT = 3'd4;

  localparam logic [1:0] SEG_SYN = 2'd0;
  localparam logic [1:0] SEG_FIN = 2'd1;

  in_item_t item;

  assign item         = in_ch.payload;
  assign in_ch.ready  = !q_full;
  assign q_push       = in_ch.valid && !q_full;

  always_comb begin
    case (item.mode)
      MODE_OPEN:    q_cmd.op = OP_OPEN;
      MODE_LISTEN:  q_cmd.op = OP_LISTEN;
      MODE_CLOSE:   q_cmd.op = OP_CLOSE;
      MODE_SEG:     q_cmd.op = OP_SEG;
      MODE_TIMEOUT: q_cmd.op = OP_TIMEOUT;
      default:      q_cmd.op = OP_BAD;
    endcase
    q_cmd.sid_ok = (32'(item.socket_id) < NUM_ENTRIES);
    q_cmd.sid    = item.socket_id;
    q_cmd.lport  = item.local_port;
    q_cmd.is_syn = (item.seg_kind == SEG_SYN);
    q_cmd.is_fin = (item.seg_kind == SEG_FIN);
    q_cmd.sport  = item.seg_src_port;
    q_cmd.dport  = item.seg_dest_port;
    q_cmd.seq    = item.seg_seq;
  end

endmodule

/* rtl/tsct_fifo.sv */
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module tsct_fifo import tsct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             q_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/tsct_back.sv */
// Back end: entry table, scan sequencer and result register.
`timescale 1ns / 1ps
`include "transport_server_connection_table_defines.svh"
module tsct_back import tsct_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t head,
  input  logic q_empty,
  output logic q_pop,
  tsct_stream_if.source out_ch
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_ENTRIES - 1);

  localparam logic [1:0] CS_CLOSED = 2'd0;
  localparam logic [1:0] CS_LISTEN = 2'd1;
  localparam logic [1:0] CS_CONN   = 2'd2;
  localparam logic [1:0] CS_CWAIT  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_READ,
    S_SCAN,
    S_SWEEP,
    S_RESP
  } bstate_t;

  bstate_t          st_r, st_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_vld_r;
  logic [NUM_ENTRIES-1:0] used_r, used_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_data_r;
  logic             out_vld_r;

  logic [1:0]  state_mem [NUM_ENTRIES];
  logic [15:0] sport_mem [NUM_ENTRIES];
  logic [15:0] cport_mem [NUM_ENTRIES];
  logic [1:0]  rd_state_r;
  logic [15:0] rd_sport_r;
  logic [15:0] rd_cport_r;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             st_we, sp_we, cp_we;
  logic [1:0]       st_wd;
  logic [15:0]      cp_wd;
  logic             issuing;
  logic             hit;
  logic             load_out;

  assign issuing  = (st_r == S_SCAN || st_r == S_SWEEP) && (idx_r < CNT_END);
  assign rd_addr  = (st_r == S_IDLE) ? IDX_W'(head.sid) : idx_r[IDX_W-1:0];
  assign hit      = chk_vld_r && used_r[chk_idx_r] && (rd_sport_r == cmd_r.dport);
  assign load_out = (st_r == S_RESP) && (!out_vld_r || out_ch.ready);

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_data_r;

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    idx_nxt  = idx_r;
    used_nxt = used_r;
    res_nxt  = res_r;
    q_pop    = 1'b0;
    wr_addr  = chk_idx_r;
    st_we    = 1'b0;
    st_wd    = CS_CLOSED;
    sp_we    = 1'b0;
    cp_we    = 1'b0;
    cp_wd    = cmd_r.sport;
    case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = head;
          idx_nxt = '0;
          res_nxt = '0;
          case (head.op)
            OP_OPEN:    st_nxt = S_FREE;
            OP_SEG:     st_nxt = S_SCAN;
            OP_TIMEOUT: st_nxt = S_SWEEP;
            OP_LISTEN, OP_CLOSE: begin
              res_nxt.entry_id = head.sid;
              if (!head.sid_ok || !used_r[IDX_W'(head.sid)]) begin
                res_nxt.status = STATUS_FAIL;
                st_nxt         = S_RESP;
              end else begin
                st_nxt = S_READ;
              end
            end
            default: begin
              res_nxt.status = STATUS_FAIL;
              st_nxt         = S_RESP;
            end
          endcase
        end
      end
      S_FREE: begin
        if (!used_r[idx_r[IDX_W-1:0]]) begin
          wr_addr           = idx_r[IDX_W-1:0];
          used_nxt[wr_addr] = 1'b1;
          st_we             = 1'b1;
          st_wd             = CS_CLOSED;
          sp_we             = 1'b1;
          cp_we             = 1'b1;
          cp_wd             = '0;
          res_nxt.entry_id  = ENTRY_W'(idx_r[IDX_W-1:0]);
          res_nxt.status    = STATUS_DONE;
          st_nxt            = S_RESP;
        end else if (idx_r == CNT_LAST) begin
          res_nxt.status = STATUS_FAIL;
          st_nxt         = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_READ: begin
        wr_addr = IDX_W'(cmd_r.sid);
        if (cmd_r.op == OP_LISTEN) begin
          st_we = 1'b1;
          st_wd = CS_LISTEN;
        end else if (rd_state_r == CS_CLOSED) begin
          used_nxt[wr_addr] = 1'b0;
        end else begin
          res_nxt.status = STATUS_FAIL;
        end
        st_nxt = S_RESP;
      end
      S_SCAN: begin
        if (hit) begin
          st_nxt                 = S_RESP;
          res_nxt.entry_id       = ENTRY_W'(chk_idx_r);
          res_nxt.status         = STATUS_IGNORED;
          res_nxt.reply_src_port = rd_sport_r;
          res_nxt.reply_dest_port = rd_cport_r;
          res_nxt.reply_seq      = cmd_r.seq;
          case (rd_state_r)
            CS_LISTEN: begin
              if (cmd_r.is_syn) begin
                cp_we                   = 1'b1;
                cp_wd                   = cmd_r.sport;
                st_we                   = 1'b1;
                st_wd                   = CS_CONN;
                res_nxt.status          = STATUS_DONE;
                res_nxt.now_connected   = 1'b1;
                res_nxt.reply_valid     = 1'b1;
                res_nxt.reply_kind      = REPLY_SYNACK;
                res_nxt.reply_dest_port = cmd_r.sport;
              end
            end
            CS_CONN: begin
              if (cmd_r.is_fin) begin
                st_we               = 1'b1;
                st_wd               = CS_CWAIT;
                res_nxt.status      = STATUS_DONE;
                res_nxt.reply_valid = 1'b1;
                res_nxt.reply_kind  = REPLY_FINACK;
              end else if (cmd_r.is_syn) begin
                res_nxt.status      = STATUS_DONE;
                res_nxt.reply_valid = 1'b1;
                res_nxt.reply_kind  = REPLY_SYNACK;
              end
            end
            CS_CWAIT: begin
              if (cmd_r.is_fin) begin
                res_nxt.status      = STATUS_DONE;
                res_nxt.reply_valid = 1'b1;
                res_nxt.reply_kind  = REPLY_FINACK;
              end
            end
            default: begin
            end
          endcase
          if (!res_nxt.reply_valid) begin
            res_nxt.reply_src_port  = '0;
            res_nxt.reply_dest_port = '0;
            res_nxt.reply_seq       = '0;
          end
        end else if (issuing) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!chk_vld_r) begin
          res_nxt.status = STATUS_IGNORED;
          st_nxt         = S_RESP;
        end
      end
      S_SWEEP: begin
        if (chk_vld_r && used_r[chk_idx_r] && rd_state_r == CS_CWAIT) begin
          st_we = 1'b1;
          st_wd = CS_CLOSED;
        end
        if (issuing) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!chk_vld_r) begin
          res_nxt.status = STATUS_DONE;
          st_nxt         = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      idx_r     <= '0;
      chk_vld_r <= 1'b0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      idx_r     <= idx_nxt;
      chk_vld_r <= issuing;
      used_r    <= used_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      cmd_r     <= cmd_nxt;
      res_r     <= res_nxt;
      chk_idx_r <= rd_addr;
      if (load_out) begin
        out_data_r <= res_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[wr_addr] <= st_wd;
    end
    if (sp_we) begin
      sport_mem[wr_addr] <= cmd_r.lport;
    end
    if (cp_we) begin
      cport_mem[wr_addr] <= cp_wd;
    end
    rd_state_r <= state_mem[rd_addr];
    rd_sport_r <= sport_mem[rd_addr];
    rd_cport_r <= cport_mem[rd_addr];
  end

  `TSCT_ASSERT_SAME(a_reply_done, st_r == S_RESP && res_r.reply_valid, res_r.status == STATUS_DONE, "reply without done status")
  `TSCT_ASSERT_SAME(a_conn_synack, st_r == S_RESP && res_r.now_connected, res_r.reply_valid && res_r.reply_kind == REPLY_SYNACK, "connect without SYNACK")
  `TSCT_ASSERT_SAME(a_idx_range, st_r != S_IDLE, idx_r <= CNT_END, "scan index past table end")
  `TSCT_ASSERT_NEXT(a_resp_loads, load_out, out_vld_r && st_r == S_IDLE, "result not loaded")

endmodule

/* rtl/transport_server_connection_table.sv */
// Top level of the server-side connection table.
//
//   channel  direction  payload     transfer when
//   in_ch    sink       in_item_t   in_ch.valid && in_ch.ready
//   out_ch   source     out_item_t  out_ch.valid && out_ch.ready
//
// The back end answers unknown modes and failed listen or close without a table
// read, reads the entry for listen and close on a used entry, and scans the table
// for open, segments and timeouts; the table scan covers one entry per cycle.
// Reset (rst_n low, synchronous) empties the table, the queue and the output.
// A two-entry queue lets the input side keep accepting while the back end
// works or while a result waits on out_ch.ready.
`timescale 1ns / 1ps
module transport_server_connection_table import tsct_pkg::*; #(
  parameter int NUM_ENTRIES = 16
) (
  input logic clk,
  input logic rst_n,
  tsct_stream_if.sink   in_ch,
  tsct_stream_if.source out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  tsct_front #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  tsct_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tsct_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
